/* rtl/aiops_pkg.sv */
// Shared types and constants of the arcade I/O port shifter.
`default_nettype none
package aiops_pkg;

    // Bus access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Port numbers
    localparam logic [2:0] PORT_ID      = 3'd0;  // read: fixed ID byte
    localparam logic [2:0] PORT_BUTTONS = 3'd1;  // read: player buttons
    localparam logic [2:0] PORT_DIP     = 3'd2;  // read: DIP switches, write: shift amount
    localparam logic [2:0] PORT_SHIFT   = 3'd3;  // read: shifted byte, write: sound bank A
    localparam logic [2:0] PORT_SHDATA  = 3'd4;  // write: push byte into shift pair
    localparam logic [2:0] PORT_SOUND_B = 3'd5;  // write: sound bank B

    localparam logic [7:0] ID_BYTE       = 8'h74;
    localparam logic [7:0] SAUCER_REPEAT = 8'd100;

    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;

    // One bus access held in the input register
    typedef struct packed {
        logic       operation;
        logic [2:0] port;
        logic [7:0] write_data;
        logic [5:0] buttons;
    } item_t;

    // One result item
    typedef struct packed {
        logic [8:0] sound_start;
        logic [7:0] read_data;
    } result_t;

endpackage
`default_nettype wire

/* rtl/aiops_in_stage.sv */
// Input register stage of the arcade I/O port shifter.
`default_nettype none
module aiops_in_stage (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] port, [10:3] write_data, [16:11] buttons, [23:17] zero
    input  wire logic [aiops_pkg::TDATA_IN_W-1:0]  s_tdata,
    // [0] operation
    input  wire logic                              s_tuser,
    input  wire logic                              advance,
    output logic                                   item_valid,
    output aiops_pkg::item_t                       item
);

    logic             valid_reg;
    logic             valid_next;
    aiops_pkg::item_t item_reg;

    // Room when empty or when the held transaction moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.operation  <= s_tuser;
            item_reg.port       <= s_tdata[2:0];
            item_reg.write_data <= s_tdata[10:3];
            item_reg.buttons    <= s_tdata[16:11];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

/* rtl/aiops_core.sv */
// Port state, shifter and sound edge detection of the arcade I/O port shifter.
`default_nettype none
module aiops_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             advance,
    input  wire aiops_pkg::item_t item,
    output aiops_pkg::result_t    result
);

    logic [7:0] dip_reg;
    logic [2:0] shift_amount_reg, shift_amount_next;
    logic [7:0] shift_low_reg, shift_low_next;
    logic [7:0] shift_high_reg, shift_high_next;
    logic [7:0] last_sound_a_reg, last_sound_a_next;
    logic [7:0] last_sound_b_reg, last_sound_b_next;
    logic [7:0] saucer_count_reg, saucer_count_next;

    logic [15:0] shifted;
    logic [7:0]  rising_a;
    logic [7:0]  rising_b;

    // DIP switch register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dip_reg <= 8'd0;
        end else if (cfg_valid) begin
            dip_reg <= cfg_data;
        end
    end

    assign shifted  = {shift_high_reg, shift_low_reg} << shift_amount_reg;
    assign rising_a = item.write_data & ~last_sound_a_reg;
    assign rising_b = item.write_data & ~last_sound_b_reg;

    // Port decode: result and next state
    always_comb begin
        shift_amount_next  = shift_amount_reg;
        shift_low_next     = shift_low_reg;
        shift_high_next    = shift_high_reg;
        last_sound_a_next  = last_sound_a_reg;
        last_sound_b_next  = last_sound_b_reg;
        saucer_count_next  = saucer_count_reg;
        result.read_data   = 8'd0;
        result.sound_start = 9'd0;

        if (item.operation == aiops_pkg::OP_READ) begin
            unique case (item.port)
                aiops_pkg::PORT_ID:      result.read_data = aiops_pkg::ID_BYTE;
                aiops_pkg::PORT_BUTTONS: result.read_data = {1'b0, item.buttons[5:3],
                                                             1'b0, item.buttons[2:0]};
                aiops_pkg::PORT_DIP:     result.read_data = dip_reg;
                aiops_pkg::PORT_SHIFT:   result.read_data = shifted[15:8];
                default:                 result.read_data = 8'd0;
            endcase
        end else begin
            unique case (item.port)
                aiops_pkg::PORT_DIP: begin
                    shift_amount_next = item.write_data[2:0];
                end
                aiops_pkg::PORT_SHIFT: begin
                    // UFO bit held high restarts its sample every repeat+1 writes
                    if (item.write_data[0]) begin
                        if (saucer_count_reg == aiops_pkg::SAUCER_REPEAT) begin
                            result.sound_start[0] = 1'b1;
                            saucer_count_next     = 8'd0;
                        end else begin
                            saucer_count_next = saucer_count_reg + 8'd1;
                        end
                    end
                    result.sound_start[3:1] = rising_a[3:1];
                    last_sound_a_next       = item.write_data;
                end
                aiops_pkg::PORT_SHDATA: begin
                    shift_low_next  = shift_high_reg;
                    shift_high_next = item.write_data;
                end
                aiops_pkg::PORT_SOUND_B: begin
                    result.sound_start[8:4] = rising_b[4:0];
                    last_sound_b_next       = item.write_data;
                end
                default: begin
                end
            endcase
        end
    end

    // State registers, updated as each transaction leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_amount_reg <= 3'd0;
            shift_low_reg    <= 8'd0;
            shift_high_reg   <= 8'd0;
            last_sound_a_reg <= 8'd0;
            last_sound_b_reg <= 8'd0;
            saucer_count_reg <= 8'd0;
        end else if (advance) begin
            shift_amount_reg <= shift_amount_next;
            shift_low_reg    <= shift_low_next;
            shift_high_reg   <= shift_high_next;
            last_sound_a_reg <= last_sound_a_next;
            last_sound_b_reg <= last_sound_b_next;
            saucer_count_reg <= saucer_count_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/arcade_io_port_shifter_top.sv */
// Top level of the arcade I/O port shifter: input stage, port logic, result register.
// Path: a transaction is taken into the input register, then moves into the result register,
// which drives m_tvalid and m_tdata until it is taken. Throughput: one transaction per cycle while
// m_tready is high; during a stall the input register takes one more, then s_tready drops.
// Reset: synchronous active-low aresetn clears both stages, all port state
// and the DIP switch byte; no clearing pass is needed.
`default_nettype none
module arcade_io_port_shifter_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [2:0] port, [10:3] write_data, [16:11] buttons, [23:17] zero
    input  wire logic [aiops_pkg::TDATA_IN_W-1:0]   s_tdata,
    // [0] operation
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [7:0] read_data, [16:8] sound_start, [23:17] zero
    output logic [aiops_pkg::TDATA_OUT_W-1:0]       m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [7:0]                         cfg_data
);

    logic               item_valid;
    logic               advance;
    aiops_pkg::item_t   item;
    aiops_pkg::result_t result;
    aiops_pkg::result_t result_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    assign cfg_ready = 1'b1;

    // Move the held transaction on when the result register is free or draining
    assign advance = item_valid && (!out_valid_reg || m_tready);

    aiops_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    aiops_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, result_reg.sound_start, result_reg.read_data};

endmodule
`default_nettype wire
